// ===== hw/rtl/pfre_pkg.sv =====
// ----------------------------------------------------------------------------
// pfre_pkg - shared types and constants of the page frame store raster engine
// Command codes, the decoded command handed from front to back, and the
// status the back end reports to the front end.
// ----------------------------------------------------------------------------
package pfre_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;

    // request op codes
    localparam logic [2:0] OP_PIXEL       = 3'd0;
    localparam logic [2:0] OP_RECT_FILL   = 3'd1;
    localparam logic [2:0] OP_RECT_INVERT = 3'd2;
    localparam logic [2:0] OP_FILL_SCREEN = 3'd3;
    localparam logic [2:0] OP_READ_BYTE   = 3'd4;

    // decoded command kinds
    localparam logic [1:0] KIND_NOP  = 2'd0;
    localparam logic [1:0] KIND_RMW  = 2'd1;
    localparam logic [1:0] KIND_FILL = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    localparam logic [7:0] BYTE_ONES    = 8'hFF;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [2:0] ROW_LAST_BIT = 3'd7;

    // command queue depth, power of two
    localparam int QUEUE_DEPTH = 2;

    // read index compare width, covers the largest store (8192 bytes)
    localparam int IDX_CMP_W = 14;

    typedef struct packed {
        logic [1:0] kind;
        logic       color;
        logic       invert;
        logic [4:0] page_first;
        logic [4:0] page_last;
        logic [2:0] row_lo;      // first row bit inside page_first
        logic [2:0] row_hi;      // last row bit inside page_last
        logic [7:0] col_first;
        logic [7:0] col_last;
        logic [9:0] read_index;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ===== hw/rtl/pfre_front.sv =====
// ----------------------------------------------------------------------------
// pfre_front - request decode and clipping
// Turns a request into a clipped command: page span, row bits at both ends,
// column span, or a read / fill / no-op.
// ----------------------------------------------------------------------------
module pfre_front #(
    parameter int SCREEN_WIDTH  = pfre_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfre_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_op,
    input  logic [7:0]            s_pos_x,
    input  logic [7:0]            s_pos_y,
    input  logic [7:0]            s_rect_width,
    input  logic [7:0]            s_rect_height,
    input  logic                  s_color,
    input  logic [9:0]            s_read_index,
    input  logic                  q_full,
    input  pfre_pkg::back_status_t status,
    output logic                  push,
    output pfre_pkg::cmd_t        push_cmd
);
    import pfre_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);
    localparam logic [8:0] HEIGHT_LIM = 9'(SCREEN_HEIGHT);
    localparam logic [IDX_CMP_W-1:0] STORE_LIM = IDX_CMP_W'(STORE_BYTES);

    logic [7:0] w_eff;
    logic [7:0] h_eff;
    logic [8:0] x_sum;
    logic [8:0] y_sum;
    logic [8:0] x_end;
    logic [8:0] y_end;
    logic [7:0] x_last;
    logic [7:0] y_last;
    logic       clipped_out;
    logic       ridx_ok;

    assign s_ready = !q_full && !status.clearing;
    assign push    = s_valid && s_ready;

    always_comb begin
        w_eff = (s_op == OP_PIXEL) ? 8'd1 : s_rect_width;
        h_eff = (s_op == OP_PIXEL) ? 8'd1 : s_rect_height;
        x_sum = {1'b0, s_pos_x} + {1'b0, w_eff};
        y_sum = {1'b0, s_pos_y} + {1'b0, h_eff};
        x_end = (x_sum > WIDTH_LIM) ? WIDTH_LIM : x_sum;
        y_end = (y_sum > HEIGHT_LIM) ? HEIGHT_LIM : y_sum;
        x_last = 8'(x_end - 9'd1);
        y_last = 8'(y_end - 9'd1);
        clipped_out = ({1'b0, s_pos_x} >= WIDTH_LIM) || ({1'b0, s_pos_y} >= HEIGHT_LIM) ||
                      (w_eff == 8'd0) || (h_eff == 8'd0);
        ridx_ok = IDX_CMP_W'(s_read_index) < STORE_LIM;

        push_cmd            = '0;
        push_cmd.color      = s_color;
        push_cmd.page_first = s_pos_y[7:3];
        push_cmd.page_last  = y_last[7:3];
        push_cmd.row_lo     = s_pos_y[2:0];
        push_cmd.row_hi     = y_last[2:0];
        push_cmd.col_first  = s_pos_x;
        push_cmd.col_last   = x_last;
        push_cmd.read_index = s_read_index;

        case (s_op)
            OP_PIXEL, OP_RECT_FILL: begin
                push_cmd.kind = clipped_out ? KIND_NOP : KIND_RMW;
            end
            OP_RECT_INVERT: begin
                push_cmd.kind   = clipped_out ? KIND_NOP : KIND_RMW;
                push_cmd.invert = 1'b1;
            end
            OP_FILL_SCREEN: begin
                push_cmd.kind = KIND_FILL;
            end
            OP_READ_BYTE: begin
                push_cmd.kind = ridx_ok ? KIND_READ : KIND_NOP;
            end
            default: begin
                push_cmd.kind = KIND_NOP;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pfre_queue.sv =====
// ----------------------------------------------------------------------------
// pfre_queue - command queue between front and back
// Small FIFO of decoded commands; lets either side stall on its own.
// ----------------------------------------------------------------------------
module pfre_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pfre_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output pfre_pkg::cmd_t pop_data
);
    import pfre_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = (PTR_W + 1)'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = (PTR_W + 1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/pfre_back.sv =====
// ----------------------------------------------------------------------------
// pfre_back - frame store and command execution
// Holds the frame store; walks store bytes with read-modify-write, sweeps
// fills and the reset clear, serves byte reads, and registers the result.
// ----------------------------------------------------------------------------
module pfre_back #(
    parameter int SCREEN_WIDTH  = pfre_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfre_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  pfre_pkg::cmd_t         q_data,
    output logic                   q_pop,
    output pfre_pkg::back_status_t status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_read_data
);
    import pfre_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_BYTES - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_WIDTH);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MODIFY = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;

    logic [7:0]        store_mem [STORE_BYTES];
    logic [7:0]        rd_data_reg;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [4:0]        page_reg;
    logic [4:0]        page_next;
    logic [7:0]        col_reg;
    logic [7:0]        col_next;
    logic [ADDR_W-1:0] row_addr_reg;
    logic [ADDR_W-1:0] row_addr_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [7:0]        pend_data_reg;
    logic [7:0]        pend_data_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [7:0]        m_data_reg;
    logic [7:0]        m_data_next;

    logic              out_free;
    logic [ADDR_W-1:0] head_addr;
    logic [ADDR_W-1:0] head_read_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              wr_en;
    logic [2:0]        lo_eff;
    logic [2:0]        hi_eff;
    logic [7:0]        row_mask;
    logic [7:0]        mod_data;
    logic              col_done;
    logic              page_done;
    logic              finish;
    logic [7:0]        finish_data;

    assign status.clearing = (state_reg == ST_CLEAR);
    assign m_valid         = m_valid_reg;
    assign m_read_data     = m_data_reg;

    always_comb begin
        out_free       = !m_valid_reg || m_ready;
        head_addr      = ADDR_W'(int'(q_data.page_first) * SCREEN_WIDTH +
                                 int'(q_data.col_first));
        head_read_addr = ADDR_W'(q_data.read_index);

        // row bits of the current page covered by the rectangle
        lo_eff   = (page_reg == cmd_reg.page_first) ? cmd_reg.row_lo : 3'd0;
        hi_eff   = (page_reg == cmd_reg.page_last) ? cmd_reg.row_hi : ROW_LAST_BIT;
        row_mask = 8'(BYTE_ONES << lo_eff) & 8'(BYTE_ONES >> 3'(ROW_LAST_BIT - hi_eff));
        if (cmd_reg.invert) begin
            mod_data = rd_data_reg ^ row_mask;
        end else if (cmd_reg.color) begin
            mod_data = rd_data_reg | row_mask;
        end else begin
            mod_data = rd_data_reg & ~row_mask;
        end
        col_done  = (col_reg == cmd_reg.col_last);
        page_done = (page_reg == cmd_reg.page_last);

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        page_next      = page_reg;
        col_next       = col_reg;
        row_addr_next  = row_addr_reg;
        addr_next      = addr_reg;
        pend_data_next = pend_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        q_pop          = 1'b0;
        rd_addr        = addr_reg;
        wr_addr        = addr_reg;
        wr_data        = mod_data;
        wr_en          = 1'b0;
        finish         = 1'b0;
        finish_data    = BYTE_ZERO;

        case (state_reg)
            ST_CLEAR: begin
                wr_en     = 1'b1;
                wr_data   = BYTE_ZERO;
                addr_next = ADDR_W'(addr_reg + 1'b1);
                if (addr_reg == LAST_ADDR) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                rd_addr = head_addr;
                if (q_valid) begin
                    q_pop         = 1'b1;
                    cmd_next      = q_data;
                    page_next     = q_data.page_first;
                    col_next      = q_data.col_first;
                    row_addr_next = head_addr;
                    addr_next     = head_addr;
                    case (q_data.kind)
                        KIND_RMW: begin
                            state_next = ST_MODIFY;
                        end
                        KIND_READ: begin
                            rd_addr    = head_read_addr;
                            state_next = ST_MODIFY;
                        end
                        KIND_FILL: begin
                            addr_next  = '0;
                            state_next = ST_FILL;
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_MODIFY: begin
                if (cmd_reg.kind == KIND_READ) begin
                    finish      = 1'b1;
                    finish_data = rd_data_reg;
                end else begin
                    wr_en = 1'b1;
                    if (col_done && page_done) begin
                        finish = 1'b1;
                    end else if (col_done) begin
                        // next page, back to the left edge
                        page_next     = 5'(page_reg + 5'd1);
                        col_next      = cmd_reg.col_first;
                        row_addr_next = ADDR_W'(row_addr_reg + ROW_STRIDE);
                        addr_next     = row_addr_next;
                        rd_addr       = row_addr_next;
                    end else begin
                        col_next  = 8'(col_reg + 8'd1);
                        addr_next = ADDR_W'(addr_reg + 1'b1);
                        rd_addr   = addr_next;
                    end
                end
            end
            ST_FILL: begin
                wr_en     = 1'b1;
                wr_data   = cmd_reg.color ? BYTE_ONES : BYTE_ZERO;
                addr_next = ADDR_W'(addr_reg + 1'b1);
                if (addr_reg == LAST_ADDR) begin
                    addr_next = '0;
                    finish    = 1'b1;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_data_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // hand the result to the output register, or park it
        if (finish) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_data_next  = finish_data;
                state_next   = ST_IDLE;
            end else begin
                pend_data_next = finish_data;
                state_next     = ST_WAIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        page_reg      <= page_next;
        col_reg       <= col_next;
        row_addr_reg  <= row_addr_next;
        pend_data_reg <= pend_data_next;
        m_data_reg    <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

endmodule

// ===== hw/rtl/page_framebuffer_raster_engine.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_raster_engine - 1 bpp page-organized frame store engine
// Pixel, rectangle fill / invert, whole-screen fill and byte readback on a
// frame store of pages of 8 rows; one result per request.
// ----------------------------------------------------------------------------
//
//  channel   ports                       carries
//  --------  --------------------------  -----------------------------------
//  request   s_valid / s_ready / s_*     op, position, size, color, index
//  result    m_valid / m_ready / m_*     read_data (store byte, else zero)
//
//  A pixel rewrites one store byte and a read fetches one; a rectangle walks
//  one store byte per cycle over the bytes it touches (columns x pages after
//  clipping); a screen fill writes all SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8)
//  store bytes; a no-op touches no store byte.
//  After reset a clearing pass zeroes the store, with s_ready low throughout.
//  A two-entry command queue keeps s_ready up while the back end works, until
//  the queue fills; a stalled result parks in the back end until the output register frees.
//
module page_framebuffer_raster_engine #(
    parameter int SCREEN_WIDTH  = pfre_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfre_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic       aclk,
    input  logic       aresetn,
    // request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [7:0] s_pos_x,
    input  logic [7:0] s_pos_y,
    input  logic [7:0] s_rect_width,
    input  logic [7:0] s_rect_height,
    input  logic       s_color,
    input  logic [9:0] s_read_index,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data
);
    import pfre_pkg::*;

    logic         push;
    cmd_t         push_cmd;
    logic         q_full;
    logic         q_pop;
    logic         q_valid;
    cmd_t         q_data;
    back_status_t status;

    // front: decode and clip each request
    pfre_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_rect_width (s_rect_width),
        .s_rect_height(s_rect_height),
        .s_color      (s_color),
        .s_read_index (s_read_index),
        .q_full       (q_full),
        .status       (status),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // decoded commands waiting for the store
    pfre_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_valid(q_valid),
        .pop_data (q_data)
    );

    // back: store walk, fills, reads, result register
    pfre_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .status     (status),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_read_data(m_read_data)
    );

endmodule

// ===== hw/rtl/pfre_checker.sv =====
// ----------------------------------------------------------------------------
// pfre_checker - port-level checks of the raster engine
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module pfre_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [2:0] s_op,
    input logic [7:0] s_pos_x,
    input logic [7:0] s_pos_y,
    input logic [7:0] s_rect_width,
    input logic [7:0] s_rect_height,
    input logic       s_color,
    input logic [9:0] s_read_index,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data
);
    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       req_take;
    logic       res_take;

    assign req_take = s_valid && s_ready;
    assign res_take = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (req_take && !res_take) begin
            pending_next = 4'(pending_reg + 4'd1);
        end else if (res_take && !req_take) begin
            pending_next = 4'(pending_reg - 4'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // a waiting request stays offered with the same payload
    a_request_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable({s_op, s_pos_x, s_pos_y,
            s_rect_width, s_rect_height, s_color, s_read_index}))
        else $error("request changed while waiting");

    // a stalled result stays offered
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_read_data))
        else $error("result data changed while stalled");

    // after reset: clearing pass blocks requests, no result offered
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("activity right after reset");

    // every result answers an earlier request
    a_no_extra_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_take |-> pending_reg != 4'd0)
        else $error("result without outstanding request");

endmodule

bind page_framebuffer_raster_engine pfre_checker u_pfre_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .s_pos_x      (s_pos_x),
    .s_pos_y      (s_pos_y),
    .s_rect_width (s_rect_width),
    .s_rect_height(s_rect_height),
    .s_color      (s_color),
    .s_read_index (s_read_index),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_data  (m_read_data)
);
